/* sv/press_length_clock_setter_macros.svh */
// ----------------------------------------------------------------------------
// Press-length clock setter assertion macros
// Shared property wrappers for the checker, clocked on clk_i and disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PRESS_LENGTH_CLOCK_SETTER_MACROS_SVH
`define PRESS_LENGTH_CLOCK_SETTER_MACROS_SVH

// Consequent checked in the same cycle that the antecedent ends.
`define PLCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent ends.
`define PLCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/plcs_pkg.sv */
// ----------------------------------------------------------------------------
// plcs_pkg
// Types, register map and reset values of the press-length clock setter.
// ----------------------------------------------------------------------------
package plcs_pkg;

  // Setting mode of the clock.
  typedef enum logic [1:0] {
    MODE_MIN  = 2'd0,
    MODE_HR   = 2'd1,
    MODE_DONE = 2'd2
  } mode_e;

  // Press event reported with each result.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_ev_e;

  // Register map: word index taken from paddr[2].
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_SAMPLE_PERIOD = 1'b0;
  localparam logic REG_LONG_COUNT    = 1'b1;

  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd1000;
  localparam logic [15:0] LONG_COUNT_RST    = 16'd50;

endpackage

/* sv/press_length_clock_setter.sv */
// ----------------------------------------------------------------------------
// press_length_clock_setter
// Samples a button level once per divider period, classifies short and long
// presses, and uses them to set a BCD hours:minutes time.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+--------------------------
//  in       | input     | in_valid_i / in_stall_o    | button_pressed_i
//  out      | output    | out_valid_o / out_stall_i  | mode, press_event, digits
//  config   | input     | psel/penable/pwrite/pready | sample_period, long_count
//
// One request is accepted per cycle while in_stall_o is low; its result leaves
// through an input register and the state/result registers.
// The state update is one pass of counter, compare and BCD increment logic.
// A stalled output holds the state, and the input register then holds one
// more request before in_stall_o rises.
// Reset clears all counters, the mode and the time, and loads the register
// reset values.
// ----------------------------------------------------------------------------
module press_length_clock_setter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          button_pressed_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    mode_o,
  output logic [1:0]                    press_event_o,
  output logic [3:0]                    minute_ones_o,
  output logic [2:0]                    minute_tens_o,
  output logic [3:0]                    hour_ones_o,
  output logic [1:0]                    hour_tens_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plcs_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Configuration registers.
  logic [15:0] sample_period_q;
  logic [15:0] long_count_q;

  // Input register.
  logic s1_valid_q;
  logic s1_button_q;

  // State, which also serves as the result register.
  logic [15:0]          div_q,  div_d;
  logic [15:0]          held_q, held_d;
  plcs_pkg::mode_e      mode_q, mode_d;
  logic [3:0]           mu_q,   mu_d;
  logic [2:0]           mt_q,   mt_d;
  logic [3:0]           hu_q,   hu_d;
  logic [1:0]           ht_q,   ht_d;
  plcs_pkg::press_ev_e  ev_q,   ev_d;
  logic                 out_valid_q;

  logic adv;
  logic fire;
  logic cfg_wr;

  // Configuration writes and reads.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q <= plcs_pkg::SAMPLE_PERIOD_RST;
      long_count_q    <= plcs_pkg::LONG_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        plcs_pkg::REG_SAMPLE_PERIOD: sample_period_q <= pwdata[15:0];
        plcs_pkg::REG_LONG_COUNT:    long_count_q    <= pwdata[15:0];
        default:                     sample_period_q <= sample_period_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      plcs_pkg::REG_SAMPLE_PERIOD: prdata = {16'd0, sample_period_q};
      plcs_pkg::REG_LONG_COUNT:    prdata = {16'd0, long_count_q};
      default:                     prdata = 32'd0;
    endcase
  end

  // The result register advances when it is empty or being taken.
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && adv;
  assign in_stall_o = s1_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_button_q <= button_pressed_i;
    end
  end

  // One tick of the divider, press classifier and time setter.
  always_comb begin
    div_d  = div_q;
    held_d = held_q;
    mode_d = mode_q;
    mu_d   = mu_q;
    mt_d   = mt_q;
    hu_d   = hu_q;
    ht_d   = ht_q;
    ev_d   = plcs_pkg::EV_NONE;
    if (mode_q != plcs_pkg::MODE_DONE) begin
      // Sample the button once the divider passes the period.
      if (div_d > sample_period_q) begin
        if (s1_button_q && (held_d != 16'hFFFF)) begin
          held_d = held_d + 16'd1;
        end
        div_d = 16'd0;
      end
      if (div_d != 16'hFFFF) begin
        div_d = div_d + 16'd1;
      end
      // Release after a few held samples is a short press.
      if (!s1_button_q && (held_d > 16'd1) && (held_d < long_count_q)) begin
        held_d = 16'd0;
        ev_d   = plcs_pkg::EV_SHORT;
      end
      // Reaching the long count is a long press, even while still held.
      if (held_d >= long_count_q) begin
        held_d = 16'd0;
        ev_d   = plcs_pkg::EV_LONG;
      end
      if (ev_d == plcs_pkg::EV_LONG) begin
        unique case (mode_q)
          plcs_pkg::MODE_MIN: mode_d = plcs_pkg::MODE_HR;
          plcs_pkg::MODE_HR:  mode_d = plcs_pkg::MODE_DONE;
          default:            mode_d = plcs_pkg::MODE_DONE;
        endcase
      end else if (ev_d == plcs_pkg::EV_SHORT) begin
        if (mode_q == plcs_pkg::MODE_MIN) begin
          // Minutes count 00 to 59.
          mu_d = mu_d + 4'd1;
          if (mu_d > 4'd9) begin
            mu_d = 4'd0;
            mt_d = mt_d + 3'd1;
            if (mt_d > 3'd5) begin
              mt_d = 3'd0;
            end
          end
        end else if (mode_q == plcs_pkg::MODE_HR) begin
          // Hours count 00 to 23.
          hu_d = hu_d + 4'd1;
          if (hu_d > 4'd9) begin
            hu_d = 4'd0;
            ht_d = ht_d + 2'd1;
            if (ht_d > 2'd2) begin
              ht_d = 2'd0;
            end
          end
          if ((ht_d >= 2'd2) && (hu_d > 4'd3)) begin
            ht_d = 2'd0;
            hu_d = 4'd0;
          end
        end
      end
    end
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q  <= 16'd0;
      held_q <= 16'd0;
      mode_q <= plcs_pkg::MODE_MIN;
      mu_q   <= 4'd0;
      mt_q   <= 3'd0;
      hu_q   <= 4'd0;
      ht_q   <= 2'd0;
      ev_q   <= plcs_pkg::EV_NONE;
    end else if (fire) begin
      div_q  <= div_d;
      held_q <= held_d;
      mode_q <= mode_d;
      mu_q   <= mu_d;
      mt_q   <= mt_d;
      hu_q   <= hu_d;
      ht_q   <= ht_d;
      ev_q   <= ev_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mode_o        = mode_q;
  assign press_event_o = ev_q;
  assign minute_ones_o = mu_q;
  assign minute_tens_o = mt_q;
  assign hour_ones_o   = hu_q;
  assign hour_tens_o   = ht_q;

endmodule

/* sv/plcs_checker.sv */
// ----------------------------------------------------------------------------
// plcs_checker
// Port-level checks of the press-length clock setter, bound to the top level.
// ----------------------------------------------------------------------------
`include "press_length_clock_setter_macros.svh"

module plcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  mode_o,
  input logic [1:0]  press_event_o,
  input logic [3:0]  minute_ones_o,
  input logic [2:0]  minute_tens_o,
  input logic [3:0]  hour_ones_o,
  input logic [1:0]  hour_tens_o
);

  logic        taken;
  logic        not_long;
  logic        done_acc;
  logic        done_idle;
  logic        time_ok;
  logic [12:0] hhmm;

  // Result handshake terms and the shown time as one vector.
  assign taken     = out_valid_o && !out_stall_i;
  assign not_long  = out_valid_o && (press_event_o != plcs_pkg::EV_LONG);
  assign done_acc  = taken && (mode_o == plcs_pkg::MODE_DONE);
  assign done_idle = (mode_o == plcs_pkg::MODE_DONE) &&
                     (press_event_o == plcs_pkg::EV_NONE);
  assign hhmm      = {hour_tens_o, hour_ones_o, minute_tens_o, minute_ones_o};

  // A legal 24-hour BCD time.
  assign time_ok = (minute_ones_o <= 4'd9) && (minute_tens_o <= 3'd5) &&
                   (hour_ones_o <= 4'd9) && (hour_tens_o <= 2'd2) &&
                   !((hour_tens_o == 2'd2) && (hour_ones_o > 4'd3));

  // A result is taken and the next one, which is not a long press, follows.
  sequence s_taken_not_long;
    taken ##1 not_long;
  endsequence

  sequence s_done_next;
    done_acc ##1 out_valid_o;
  endsequence

  // A stalled result stays offered.
  `PLCS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")

  // Shown time is a legal 24-hour BCD time whenever a result is valid.
  `PLCS_ASSERT_SAME(a_time_legal, out_valid_o, time_ok, "illegal BCD time")

  // The mode only moves on a long press.
  `PLCS_ASSERT_SAME(a_mode_on_long, s_taken_not_long, $stable(mode_o), "mode moved")

  // Once done, the time freezes and no press is reported.
  `PLCS_ASSERT_SAME(a_done_frozen, s_done_next, done_idle && $stable(hhmm), "done not frozen")

endmodule

bind press_length_clock_setter plcs_checker u_plcs_checker (.*);

/* bench/clock_setter_checker.sv */
// ----------------------------------------------------------------------------
// clock_setter_checker
// Watches the request, result and register channels of the press-length
// clock setter. Each accepted request is run through a cycle-free model of
// the divider, the press classifier and the BCD time digits. Each accepted
// result is compared, field by field, with the oldest pending prediction.
// ----------------------------------------------------------------------------
module clock_setter_checker
  import plcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request channel
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 button_pressed_i,
  // Result channel
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [1:0]           mode_i,
  input  logic [1:0]           press_event_i,
  input  logic [3:0]           minute_ones_i,
  input  logic [2:0]           minute_tens_i,
  input  logic [3:0]           hour_ones_i,
  input  logic [1:0]           hour_tens_i,
  // Register port
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [PADDR_W-1:0]   paddr_i,
  input  logic [31:0]          pwdata_i,
  input  logic                 pready_i,
  // Status for the stimulus side
  output int unsigned          pending_o,
  output int unsigned          mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // What the block shows after one tick.
  typedef struct packed {
    mode_e       mode;
    press_ev_e   ev;
    logic [3:0]  min_ones;
    logic [2:0]  min_tens;
    logic [3:0]  hr_ones;
    logic [1:0]  hr_tens;
  } clock_view_t;

  clock_view_t expected_views[$];
  int unsigned result_count;

  // Shadow copy of the settings and of the block's state.
  logic [15:0] period_q;
  logic [15:0] long_q;
  logic [15:0] divider_q;
  logic [15:0] held_q;
  mode_e       mode_q;
  logic [3:0]  min_ones_q;
  logic [2:0]  min_tens_q;
  logic [3:0]  hr_ones_q;
  logic [1:0]  hr_tens_q;

  // One tick: sample the button, classify the press and set the time.
  function automatic clock_view_t advance_clock(logic pressed);
    press_ev_e ev;
    ev = EV_NONE;
    if (mode_q != MODE_DONE) begin
      // The divider is compared before it counts, so a sample comes
      // every period+1 ticks.
      if (divider_q > period_q) begin
        if (pressed && held_q != 16'hFFFF) held_q = held_q + 16'd1;
        divider_q = '0;
      end
      if (divider_q != 16'hFFFF) divider_q = divider_q + 16'd1;
      if (!pressed && held_q > 16'd1 && held_q < long_q) begin
        held_q = '0;
        ev = EV_SHORT;
      end
      // A long press fires while the button is still down.
      if (held_q >= long_q) begin
        held_q = '0;
        ev = EV_LONG;
      end
      if (ev == EV_LONG) begin
        mode_q = (mode_q == MODE_MIN) ? MODE_HR : MODE_DONE;
      end else if (ev == EV_SHORT && mode_q == MODE_MIN) begin
        min_ones_q = min_ones_q + 4'd1;
        if (min_ones_q > 4'd9) begin
          min_ones_q = '0;
          min_tens_q = min_tens_q + 3'd1;
          if (min_tens_q > 3'd5) min_tens_q = '0;
        end
      end else if (ev == EV_SHORT && mode_q == MODE_HR) begin
        hr_ones_q = hr_ones_q + 4'd1;
        if (hr_ones_q > 4'd9) begin
          hr_ones_q = '0;
          hr_tens_q = hr_tens_q + 2'd1;
          if (hr_tens_q > 2'd2) hr_tens_q = '0;
        end
        // Hours wrap from 23 to 00.
        if (hr_tens_q >= 2'd2 && hr_ones_q > 4'd3) begin
          hr_tens_q = '0;
          hr_ones_q = '0;
        end
      end
    end
    return '{mode_q, ev, min_ones_q, min_tens_q, hr_ones_q, hr_tens_q};
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count_o = mismatch_count_o + 1;
  endtask

  // Track register writes, predict on each request, check each result.
  always @(posedge clk_i or negedge rst_ni) begin
    clock_view_t want;
    clock_view_t got;
    if (!rst_ni) begin
      period_q = SAMPLE_PERIOD_RST;
      long_q = LONG_COUNT_RST;
      divider_q = '0;
      held_q = '0;
      mode_q = MODE_MIN;
      min_ones_q = '0;
      min_tens_q = '0;
      hr_ones_q = '0;
      hr_tens_q = '0;
      expected_views.delete();
      result_count = 0;
      mismatch_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_SAMPLE_PERIOD) period_q = pwdata_i[15:0];
        else long_q = pwdata_i[15:0];
      end
      if (in_valid_i && !in_stall_i) begin
        expected_views.push_back(advance_clock(button_pressed_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{mode_e'(mode_i), press_ev_e'(press_event_i), minute_ones_i, minute_tens_i,
                hour_ones_i, hour_tens_i};
        if (expected_views.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
        end else begin
          want = expected_views.pop_front();
          if (got.mode !== want.mode)
            flag_mismatch($sformatf("result %0d mode %0d, expected %0d",
                                    result_count, got.mode, want.mode));
          if (got.ev !== want.ev)
            flag_mismatch($sformatf("result %0d press_event %0d, expected %0d",
                                    result_count, got.ev, want.ev));
          if (got.min_ones !== want.min_ones)
            flag_mismatch($sformatf("result %0d minute_ones %0d, expected %0d",
                                    result_count, got.min_ones, want.min_ones));
          if (got.min_tens !== want.min_tens)
            flag_mismatch($sformatf("result %0d minute_tens %0d, expected %0d",
                                    result_count, got.min_tens, want.min_tens));
          if (got.hr_ones !== want.hr_ones)
            flag_mismatch($sformatf("result %0d hour_ones %0d, expected %0d",
                                    result_count, got.hr_ones, want.hr_ones));
          if (got.hr_tens !== want.hr_tens)
            flag_mismatch($sformatf("result %0d hour_tens %0d, expected %0d",
                                    result_count, got.hr_tens, want.hr_tens));
        end
        result_count++;
      end
    end
    pending_o = expected_views.size();
  end

endmodule

/* bench/press_length_clock_setter_tb.sv */
// ----------------------------------------------------------------------------
// press_length_clock_setter_tb
// Drives button ticks through the press-length clock setter: a few ticks at
// the reset and the largest settings, then well-formed presses with random
// lengths that walk the minutes through a full wrap, one long press into
// hour setting, a full hour wrap, and a final long press into done mode.
// Both channels idle at random until the last phase; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module press_length_clock_setter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                button_pressed_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          mode_o;
  logic [1:0]          press_event_o;
  logic [3:0]          minute_ones_o;
  logic [2:0]          minute_tens_o;
  logic [3:0]          hour_ones_o;
  logic [1:0]          hour_tens_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned pending_results;
  int unsigned mismatch_count;
  int unsigned ticks_sent = 0;
  int unsigned idle_phase = 0;
  int unsigned cycle_count = 0;

  press_length_clock_setter u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .button_pressed_i (button_pressed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .mode_o           (mode_o),
    .press_event_o    (press_event_o),
    .minute_ones_o    (minute_ones_o),
    .minute_tens_o    (minute_tens_o),
    .hour_ones_o      (hour_ones_o),
    .hour_tens_o      (hour_tens_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  clock_setter_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .button_pressed_i (button_pressed_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .mode_i           (mode_o),
    .press_event_i    (press_event_o),
    .minute_ones_i    (minute_ones_o),
    .minute_tens_i    (minute_tens_o),
    .hour_ones_i      (hour_ones_o),
    .hour_tens_i      (hour_tens_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .pending_o        (pending_results),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Run-away guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side stalls: busy first, then light, then never.
  always @(posedge clk_i) begin
    out_stall_i <= (idle_phase == 0) ? ($urandom_range(99) < 47) :
                   (idle_phase == 1) ? ($urandom_range(99) < 21) : 1'b0;
  end

  // Sends one tick request and returns at the edge that accepts it.
  task automatic send_level(input logic level);
    int unsigned gap_pct;
    gap_pct = (idle_phase == 0) ? 21 : (idle_phase == 1) ? 47 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    button_pressed_i <= level;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticks_sent++;
    idle_phase = (ticks_sent < 230) ? 0 : (ticks_sent < 460) ? 1 : 2;
  endtask

  task automatic send_run(input logic level, input int unsigned count);
    repeat (count) send_level(level);
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input logic index, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Lets the block drain, then loads both settings.
  task automatic apply_settings(input logic [15:0] period, input logic [15:0] long_presses);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(REG_SAMPLE_PERIOD, period);
    write_reg(REG_LONG_COUNT, long_presses);
  endtask

  // Mostly a clean press long enough for two or three samples, then a
  // release; now and then a burst of random levels.
  task automatic press_sequence(input int unsigned period);
    int unsigned n;
    if ($urandom_range(19) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) send_level(1'($urandom_range(1)));
    end else begin
      send_run(1'b1, $urandom_range(2 * (period + 1), 3 * (period + 1) - 1));
      send_run(1'b0, $urandom_range(1, 2));
    end
  endtask

  task automatic press_batch(input int unsigned period, input logic [15:0] long_presses,
                             input int unsigned count);
    apply_settings(16'(period), long_presses);
    repeat (count) press_sequence(period);
    // Trailing releases leave at most one held sample behind.
    send_run(1'b0, 3);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the divider never gets near a sample.
    for (int k = 0; k < 10; k++) send_level(1'(k % 3 == 0));

    // Largest settings: no sample is taken at all.
    apply_settings(16'hFFFF, 16'hFFFF);
    send_run(1'b1, 8);
    send_run(1'b0, 2);

    // Minutes: enough short presses for a full wrap past 59.
    press_batch(1, 16'($urandom_range(1000, 65535)), 45);
    press_batch(1, 16'hFFFF, 23);

    // Long count of three: one long press, released before a second.
    apply_settings(16'd1, 16'd3);
    send_run(1'b1, 7);
    send_run(1'b0, 3);

    // Hours: enough short presses for a wrap past 23.
    press_batch(3, 16'($urandom_range(1000, 65535)), 9);
    press_batch(1, 16'hFFFF, 9);
    press_batch(2, 16'($urandom_range(1000, 65535)), 9);

    // A long count of two: the press held down ends setting.
    apply_settings(16'd1, 16'd2);
    send_run(1'b1, 8);

    // Done mode: everything is frozen.
    repeat (20) send_level(1'($urandom_range(1)));
    in_valid_i <= 1'b0;

    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
